// ===== rtl/core/swks_pkg.sv =====
// swks_pkg: shared constants and types for the sliding-window k-smallest-sum filter
// no dependencies; imported by swks_cell and sliding_window_k_smallest_sum
`default_nettype none

package swks_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 38;
	localparam int CFG_W    = 7;
	localparam int IDX_W    = 1;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [IDX_W-1:0] REG_KEEP_COUNT = 1'b1;

	localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd64;
	localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 7'd1;

	// broadcast from the controller to every cell of the sorted chain
	typedef struct packed {
		logic                upd;
		logic                evict;
		logic [SAMPLE_W-1:0] ins_val;
		logic [SAMPLE_W-1:0] del_val;
	} bcast_t;

endpackage

`default_nettype wire

// ===== rtl/core/swks_ram.sv =====
// swks_ram: generic single-port-write, single-port-read ram with registered read
// read-first on a same-address write; no dependencies
`default_nettype none

module swks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/swks_cell.sv =====
// swks_cell: one entry of the sorted sample chain plus one stage of the summing scan
// depends on swks_pkg (bcast_t, SAMPLE_W)
`default_nettype none

module swks_cell #(
	parameter int MAX_WINDOW = 64,
	parameter int AW         = $clog2(MAX_WINDOW),
	parameter int WW         = $clog2(MAX_WINDOW + 1),
	parameter int ACC_W      = 39
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swks_pkg::bcast_t              ctl,
	input  logic [WW-1:0]                 eff_w,
	input  logic [WW-1:0]                 eff_k,
	// raw entry of the right-hand neighbour
	input  logic                          nxt_occ,
	input  logic [swks_pkg::SAMPLE_W-1:0] nxt_val,
	input  logic [AW-1:0]                 nxt_age,
	// compacted entry of the left-hand neighbour
	input  logic                          prv_occ,
	input  logic [swks_pkg::SAMPLE_W-1:0] prv_val,
	input  logic [AW-1:0]                 prv_age,
	input  logic                          prv_gt,
	// own compacted entry
	output logic                          c_occ,
	output logic [swks_pkg::SAMPLE_W-1:0] c_val,
	output logic [AW-1:0]                 c_age,
	output logic                          c_gt,
	// own raw entry
	output logic                          occ,
	output logic [swks_pkg::SAMPLE_W-1:0] val,
	output logic [AW-1:0]                 age,
	// summing token
	input  logic                          tin_vld,
	input  logic [ACC_W-1:0]              tin_sum,
	input  logic [WW-1:0]                 tin_cnt,
	output logic                          tout_vld,
	output logic [ACC_W-1:0]              tout_sum,
	output logic [WW-1:0]                 tout_cnt
);
	import swks_pkg::*;

	logic                occ_q;
	logic [SAMPLE_W-1:0] val_q;
	logic [AW-1:0]       age_q;
	logic                pre_del;
	logic                take;
	logic                tvld_q;
	logic [ACC_W-1:0]    tsum_q;
	logic [WW-1:0]       tcnt_q;

	// entry sits ahead of the evicted one: oldest equal value always leads its run
	assign pre_del = !(ctl.evict && occ_q &&
		((age_q == AW'(MAX_WINDOW - 1)) || (val_q >= ctl.del_val)));

	assign c_occ = pre_del ? occ_q : nxt_occ;
	assign c_val = pre_del ? val_q : nxt_val;
	assign c_age = pre_del ? age_q : nxt_age;
	assign c_gt  = !c_occ || (c_val > ctl.ins_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.upd) begin
			priority if (!c_gt) begin
				occ_q <= c_occ;
			end else if (!prv_gt) begin
				occ_q <= 1'b1;
			end else begin
				occ_q <= prv_occ;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			priority if (!c_gt) begin
				val_q <= c_val;
				age_q <= c_age + AW'(1);
			end else if (!prv_gt) begin
				val_q <= ctl.ins_val;
				age_q <= '0;
			end else begin
				val_q <= prv_val;
				age_q <= prv_age + AW'(1);
			end
		end
	end

	// scan stage: add this entry if it is inside the window and still among the k smallest
	assign take = tin_vld && occ_q && (WW'(age_q) < eff_w) && (tin_cnt < eff_k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q <= 1'b0;
		end else begin
			tvld_q <= tin_vld;
		end
	end

	always_ff @(posedge clk) begin
		tsum_q <= take ? (tin_sum + ACC_W'(val_q)) : tin_sum;
		tcnt_q <= take ? (tin_cnt + WW'(1)) : tin_cnt;
	end

	assign occ      = occ_q;
	assign val      = val_q;
	assign age      = age_q;
	assign tout_vld = tvld_q;
	assign tout_sum = tsum_q;
	assign tout_cnt = tcnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_k_smallest_sum.sv =====
// sliding_window_k_smallest_sum: top level, controller, sample ring and sorted cell chain
// depends on swks_pkg, swks_ram and swks_cell
//
// Streaming rank-order filter. Each beat on the input channel (in_valid/in_ready, sample)
// pushes one unsigned sample into a window of the last window_len samples. Once at least
// window_len samples have arrived, each beat gives one beat on the output channel
// (out_valid/out_ready, trimmed_sum): the sum of the keep_count smallest samples in the
// window, saturated to 38 bits. Registers are written on cfg_we with cfg_idx/cfg_data,
// only while the block is idle; the user must keep to this, the block does not enforce it.
// Samples live in a chain of MAX_WINDOW cells kept sorted by value; an insert plus the
// eviction of the oldest entry are done together in state S_UPD. A summing token then walks
// down the chain one cell a cycle and its sum goes to the output register; the next
// sample is taken only once that sum is loaded. An item with no result (window still
// filling) goes from S_UPD back to S_IDLE. A finished result waits in the
// output register while the next sample is taken; if it is still unread when the next
// scan ends, that scan holds its sum until the output register frees.
// Reset empties the chain and the fill count and restores window_len 64, keep_count 1.
`default_nettype none

module sliding_window_k_smallest_sum #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swks_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [swks_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [swks_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [swks_pkg::SUM_W-1:0]    trimmed_sum
);
	import swks_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int WW    = $clog2(MAX_WINDOW + 1);
	localparam int XW    = (WW > CFG_W) ? WW : CFG_W;
	localparam int GW    = SAMPLE_W + WW;
	localparam int ACC_W = (GW > SUM_W) ? GW : SUM_W + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_UPD  = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    window_len_q;
	logic [CFG_W-1:0]    keep_count_q;
	logic [AW-1:0]       oldest_slot_q;
	logic [WW-1:0]       fill_level_q;
	logic                evict_q;
	logic                start_q;
	logic [SAMPLE_W-1:0] ins_val_q;
	logic [SAMPLE_W-1:0] del_val;
	logic [SUM_W-1:0]    done_sum_q;
	logic                out_valid_q;
	logic [SUM_W-1:0]    out_sum_q;
	logic                in_beat;
	logic                out_free;
	logic                load_out;
	logic                produce;
	logic [SUM_W-1:0]    tail_sat;
	logic [WW-1:0]       eff_w;
	logic [WW-1:0]       eff_k;
	logic [XW-1:0]       wl_x;
	logic [XW-1:0]       kc_x;
	logic [XW-1:0]       ew_x;
	bcast_t              ctl;

	// chain wiring
	logic                c_occ  [MAX_WINDOW];
	logic [SAMPLE_W-1:0] c_val  [MAX_WINDOW];
	logic [AW-1:0]       c_age  [MAX_WINDOW];
	logic                c_gt   [MAX_WINDOW];
	logic                r_occ  [MAX_WINDOW];
	logic [SAMPLE_W-1:0] r_val  [MAX_WINDOW];
	logic [AW-1:0]       r_age  [MAX_WINDOW];
	logic                t_vld  [MAX_WINDOW];
	logic [ACC_W-1:0]    t_sum  [MAX_WINDOW];
	logic [WW-1:0]       t_cnt  [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] occ_vec;
	logic [MAX_WINDOW-1:0] tvld_vec;

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = out_free &&
		(((state_q == S_SCAN) && t_vld[MAX_WINDOW-1]) || (state_q == S_DONE));

	// effective window and keep count
	always_comb begin
		wl_x = XW'(window_len_q);
		kc_x = XW'(keep_count_q);
		priority if (window_len_q == '0) begin
			eff_w = WW'(1);
		end else if (wl_x > XW'(MAX_WINDOW)) begin
			eff_w = WW'(MAX_WINDOW);
		end else begin
			eff_w = wl_x[WW-1:0];
		end
		ew_x  = XW'(eff_w);
		eff_k = (kc_x > ew_x) ? eff_w : kc_x[WW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			keep_count_q <= KEEP_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_LEN: window_len_q <= cfg_data;
				REG_KEEP_COUNT: keep_count_q <= cfg_data;
			endcase
		end
	end

	// sample ring: the slot about to be overwritten holds the evicted value
	swks_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (in_beat),
		.waddr (oldest_slot_q),
		.wdata (sample),
		.raddr (oldest_slot_q),
		.rdata (del_val)
	);

	assign produce = (fill_level_q >= eff_w);

	assign tail_sat = (|t_sum[MAX_WINDOW-1][ACC_W-1:SUM_W]) ? {SUM_W{1'b1}}
		: t_sum[MAX_WINDOW-1][SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			oldest_slot_q <= '0;
			fill_level_q  <= '0;
			evict_q       <= 1'b0;
			start_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			start_q <= (state_q == S_UPD) && produce;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						oldest_slot_q <= (oldest_slot_q == AW'(MAX_WINDOW - 1)) ? '0
							: oldest_slot_q + AW'(1);
						evict_q <= (fill_level_q == WW'(MAX_WINDOW));
						if (fill_level_q != WW'(MAX_WINDOW)) begin
							fill_level_q <= fill_level_q + WW'(1);
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (produce) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (t_vld[MAX_WINDOW-1]) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			ins_val_q <= sample;
		end
		if (state_q == S_SCAN && t_vld[MAX_WINDOW-1]) begin
			done_sum_q <= tail_sat;
			if (out_free) begin
				out_sum_q <= tail_sat;
			end
		end else if (state_q == S_DONE && out_free) begin
			out_sum_q <= done_sum_q;
		end
	end

	assign ctl.upd     = (state_q == S_UPD);
	assign ctl.evict   = evict_q;
	assign ctl.ins_val = ins_val_q;
	assign ctl.del_val = del_val;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic                n_occ;
		logic [SAMPLE_W-1:0] n_val;
		logic [AW-1:0]       n_age;
		logic                p_occ;
		logic [SAMPLE_W-1:0] p_val;
		logic [AW-1:0]       p_age;
		logic                p_gt;
		logic                i_vld;
		logic [ACC_W-1:0]    i_sum;
		logic [WW-1:0]       i_cnt;

		if (i == MAX_WINDOW - 1) begin : g_tail
			assign n_occ = 1'b0;
			assign n_val = '0;
			assign n_age = '0;
		end else begin : g_mid
			assign n_occ = r_occ[i+1];
			assign n_val = r_val[i+1];
			assign n_age = r_age[i+1];
		end

		if (i == 0) begin : g_head
			assign p_occ = 1'b0;
			assign p_val = '0;
			assign p_age = '0;
			assign p_gt  = 1'b0;
			assign i_vld = start_q;
			assign i_sum = '0;
			assign i_cnt = '0;
		end else begin : g_body
			assign p_occ = c_occ[i-1];
			assign p_val = c_val[i-1];
			assign p_age = c_age[i-1];
			assign p_gt  = c_gt[i-1];
			assign i_vld = t_vld[i-1];
			assign i_sum = t_sum[i-1];
			assign i_cnt = t_cnt[i-1];
		end

		swks_cell #(
			.MAX_WINDOW (MAX_WINDOW),
			.AW         (AW),
			.WW         (WW),
			.ACC_W      (ACC_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.eff_w    (eff_w),
			.eff_k    (eff_k),
			.nxt_occ  (n_occ),
			.nxt_val  (n_val),
			.nxt_age  (n_age),
			.prv_occ  (p_occ),
			.prv_val  (p_val),
			.prv_age  (p_age),
			.prv_gt   (p_gt),
			.c_occ    (c_occ[i]),
			.c_val    (c_val[i]),
			.c_age    (c_age[i]),
			.c_gt     (c_gt[i]),
			.occ      (r_occ[i]),
			.val      (r_val[i]),
			.age      (r_age[i]),
			.tin_vld  (i_vld),
			.tin_sum  (i_sum),
			.tin_cnt  (i_cnt),
			.tout_vld (t_vld[i]),
			.tout_sum (t_sum[i]),
			.tout_cnt (t_cnt[i])
		);

		assign occ_vec[i]  = r_occ[i];
		assign tvld_vec[i] = t_vld[i];
	end

	assign out_valid   = out_valid_q;
	assign trimmed_sum = out_sum_q;

	// only one summing token is ever in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tvld_vec))
		else $error("more than one summing token in the chain");

	// a token only reaches the tail while the controller waits for it
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		t_vld[MAX_WINDOW-1] |-> (state_q == S_SCAN))
		else $error("summing token left the chain outside the scan");

	// between items the chain holds exactly as many entries as the fill count
	a_occ_matches_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(occ_vec) == 32'(fill_level_q)))
		else $error("occupied cells disagree with fill level");

	// the chain stays packed: an occupied entry never follows an empty one
	a_occ_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((occ_vec & (occ_vec + 1'b1)) == '0))
		else $error("occupied cells are not packed at the head of the chain");

endmodule

`default_nettype wire
